// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, off while reset is high
`define OWB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// implication checked in the next cycle, off while reset is high
`define OWB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// implication checked in the next cycle, also through reset
`define OWB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("reset-time check failed");

`endif

// ----- sv/owbmd_pkg.sv -----
// shared types and constants of the 1-wire bus monitor decoder
package owbmd_pkg;

  // event codes on event_kind
  localparam logic [1:0] EV_RESET    = 2'd0;
  localparam logic [1:0] EV_PRESENCE = 2'd1;
  localparam logic [1:0] EV_BYTE     = 2'd2;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_ONE_LIMIT      = 2'd0;
  localparam logic [1:0] REG_PRESENCE_LIMIT = 2'd1;
  localparam logic [1:0] REG_RESET_LIMIT    = 2'd2;

  // register reset values
  localparam logic [15:0] ONE_LIMIT_INIT      = 16'd15;
  localparam logic [15:0] PRESENCE_LIMIT_INIT = 16'd50;
  localparam logic [15:0] RESET_LIMIT_INIT    = 16'd250;

  // classified line events passed from front to back
  typedef enum logic [1:0] {
    TOK_RESET,
    TOK_PRESENCE,
    TOK_SKIP,
    TOK_BIT
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t kind;
    logic      bit_value;
  } token_t;

  // limits seen by the front
  typedef struct packed {
    logic [15:0] one_limit;
    logic [15:0] presence_limit;
    logic [15:0] reset_limit;
  } limits_t;

endpackage

// ----- sv/owbmd_front.sv -----
// front: line sampling, low-time counter and slot classification
module owbmd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              line_level,
  input  logic              q_full,
  input  owbmd_pkg::limits_t limits,
  output logic              push,
  output owbmd_pkg::token_t tok
);

  logic        prev_level, prev_level_next;
  logic [15:0] low_ticks, low_ticks_next;
  logic        timing_active, timing_active_next;
  logic        skip_next_edge, skip_next_edge_next;
  logic        accept;
  logic [15:0] count_step;

  assign accept = in_valid && !q_full;

  // saturating increment of the low-time counter
  assign count_step = (low_ticks == 16'hFFFF) ? low_ticks : low_ticks + 16'd1;

  // classify the sample and update the timing state
  always_comb begin
    prev_level_next     = prev_level;
    low_ticks_next      = low_ticks;
    timing_active_next  = timing_active;
    skip_next_edge_next = skip_next_edge;
    push                = 1'b0;
    tok.kind            = owbmd_pkg::TOK_BIT;
    tok.bit_value       = 1'b0;
    if (accept) begin
      prev_level_next = line_level;
      if (!line_level) begin
        // falling edge starts the count, held low keeps counting while timing is active
        if (prev_level) begin
          timing_active_next = 1'b1;
          low_ticks_next     = 16'd1;
        end else if (timing_active) begin
          low_ticks_next = count_step;
        end
        if (timing_active_next && (low_ticks_next >= limits.reset_limit)) begin
          timing_active_next  = 1'b0;
          low_ticks_next      = 16'd0;
          skip_next_edge_next = 1'b1;
          push                = 1'b1;
          tok.kind            = owbmd_pkg::TOK_RESET;
        end
      end else if (!prev_level) begin
        // rising edge ends the slot
        timing_active_next = 1'b0;
        push               = 1'b1;
        priority if (skip_next_edge) begin
          skip_next_edge_next = 1'b0;
          tok.kind            = owbmd_pkg::TOK_SKIP;
        end else if (low_ticks > limits.presence_limit) begin
          low_ticks_next = 16'd0;
          tok.kind       = owbmd_pkg::TOK_PRESENCE;
        end else begin
          tok.kind      = owbmd_pkg::TOK_BIT;
          tok.bit_value = (low_ticks <= limits.one_limit);
        end
      end
    end
  end

  // timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level     <= 1'b1;
      low_ticks      <= 16'd0;
      timing_active  <= 1'b0;
      skip_next_edge <= 1'b0;
    end else begin
      prev_level     <= prev_level_next;
      low_ticks      <= low_ticks_next;
      timing_active  <= timing_active_next;
      skip_next_edge <= skip_next_edge_next;
    end
  end

endmodule

// ----- sv/owbmd_queue.sv -----
// short queue of classified line events between front and back
module owbmd_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  owbmd_pkg::token_t push_tok,
  input  logic              pop,
  output logic              q_valid,
  output owbmd_pkg::token_t q_tok,
  output logic              full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  owbmd_pkg::token_t slots [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic              do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_tok   = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ----- sv/owbmd_back.sv -----
// back: bit assembly and the output word register
module owbmd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  owbmd_pkg::token_t q_tok,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_kind,
  output logic [7:0]        byte_value
);

  logic [2:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] shifted;
  logic       out_valid_next;
  logic       emit;
  logic [1:0] kind_load;
  logic [7:0] value_load;

  assign pop     = q_valid && (!out_valid || !out_stall);
  assign shifted = {q_tok.bit_value, shift_byte[7:1]};

  // carry out one event from the queue
  always_comb begin
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    emit            = 1'b0;
    kind_load       = owbmd_pkg::EV_RESET;
    value_load      = 8'd0;
    if (pop) begin
      unique case (q_tok.kind)
        owbmd_pkg::TOK_RESET: begin
          bit_count_next  = 3'd0;
          shift_byte_next = 8'd0;
          emit            = 1'b1;
          kind_load       = owbmd_pkg::EV_RESET;
        end
        owbmd_pkg::TOK_PRESENCE: begin
          bit_count_next  = 3'd0;
          shift_byte_next = 8'd0;
          emit            = 1'b1;
          kind_load       = owbmd_pkg::EV_PRESENCE;
        end
        owbmd_pkg::TOK_SKIP: begin
          shift_byte_next = {1'b0, shift_byte[7:1]};
        end
        owbmd_pkg::TOK_BIT: begin
          bit_count_next = bit_count + 3'd1;
          if (bit_count == 3'd7) begin
            shift_byte_next = 8'd0;
            emit            = 1'b1;
            kind_load       = owbmd_pkg::EV_BYTE;
            value_load      = shifted;
          end else begin
            shift_byte_next = shifted;
          end
        end
        default: begin
          shift_byte_next = shift_byte;
        end
      endcase
    end
  end

  // output word stays until taken
  assign out_valid_next = pop ? emit : (out_valid && out_stall);

  // control and assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      bit_count  <= 3'd0;
      shift_byte <= 8'd0;
    end else begin
      out_valid  <= out_valid_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      event_kind <= kind_load;
      byte_value <= value_load;
    end
  end

endmodule

// ----- sv/one_wire_bus_monitor_decoder_core.sv -----
// Passive 1-wire bus monitor. One line sample is taken per clock cycle, every cycle, as
// long as the output side keeps up; a sample's event passes through the event queue,
// then the output register. in_stall rises only once the QUEUE_DEPTH-entry event
// queue has filled behind a stalled output word.
// Events: reset pulse, presence pulse, and each completed byte (LSB first). Limits are
// set through the register port: one_limit at 0x0, presence_limit at 0x4, reset_limit
// at 0x8.
module one_wire_bus_monitor_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        line_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_kind,
  output logic [7:0]  byte_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  owbmd_pkg::limits_t limits;
  owbmd_pkg::token_t  front_tok;
  owbmd_pkg::token_t  q_tok;
  logic               front_push;
  logic               q_full;
  logic               q_valid;
  logic               back_pop;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = q_full;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.one_limit      <= owbmd_pkg::ONE_LIMIT_INIT;
      limits.presence_limit <= owbmd_pkg::PRESENCE_LIMIT_INIT;
      limits.reset_limit    <= owbmd_pkg::RESET_LIMIT_INIT;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        owbmd_pkg::REG_ONE_LIMIT:      limits.one_limit      <= pwdata[15:0];
        owbmd_pkg::REG_PRESENCE_LIMIT: limits.presence_limit <= pwdata[15:0];
        owbmd_pkg::REG_RESET_LIMIT:    limits.reset_limit    <= pwdata[15:0];
        default: begin
          limits <= limits;
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      owbmd_pkg::REG_ONE_LIMIT:      prdata = {16'd0, limits.one_limit};
      owbmd_pkg::REG_PRESENCE_LIMIT: prdata = {16'd0, limits.presence_limit};
      owbmd_pkg::REG_RESET_LIMIT:    prdata = {16'd0, limits.reset_limit};
      default:                       prdata = 32'd0;
    endcase
  end

  owbmd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .line_level (line_level),
    .q_full     (q_full),
    .limits     (limits),
    .push       (front_push),
    .tok        (front_tok)
  );

  owbmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_tok (front_tok),
    .pop      (back_pop),
    .q_valid  (q_valid),
    .q_tok    (q_tok),
    .full     (q_full)
  );

  owbmd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_tok      (q_tok),
    .pop        (back_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .byte_value (byte_value)
  );

endmodule

// ----- sv/owbmd_checker.sv -----
// port-level checks of the bus monitor decoder and their bind
`include "assert_macros.svh"

module owbmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] event_kind,
  input logic [7:0] byte_value
);

  // a stalled output word holds
  `OWB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(event_kind) && $stable(byte_value))

  // only byte words carry data
  `OWB_ASSERT_SAME(a_value_zero, clk, rst, out_valid && (event_kind != owbmd_pkg::EV_BYTE), byte_value == 8'd0)

  // the input side stalls only behind a waiting output word
  `OWB_ASSERT_SAME(a_stall_cause, clk, rst, !out_valid, !in_stall)

  // reset empties the output
  `OWB_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, !out_valid && !in_stall)

endmodule

bind one_wire_bus_monitor_decoder_core owbmd_checker u_owbmd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .event_kind (event_kind),
  .byte_value (byte_value)
);
